// ----- hdl/lfps_pkg.sv -----
// Shared types, constants and codes for the line follower PID steering block.
package lfps_pkg;

	// Sensor row and field widths
	localparam int NUM_SENSORS = 5;
	localparam int SAMPLE_W    = 12;
	localparam int ERR_W       = 12;
	localparam int TGT_W       = 9;
	localparam int DIFF_W      = 9;
	localparam int GAIN_W      = 18;
	localparam int INTEG_W     = 13;
	localparam int CNT_W       = 4;
	localparam int MODE_W      = 2;
	localparam int CLS_W       = 2;
	localparam int DIR_W       = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 18;

	// Product and accumulator widths (gain x 13-bit operand, three terms)
	localparam int OPND_W = ERR_W + 1;
	localparam int PROD_W = GAIN_W + OPND_W;
	localparam int ACC_W  = PROD_W + 2;

	// Queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Limits
	localparam logic [TGT_W-1:0]          TARGET_LIMIT = 9'd300;
	localparam logic [TGT_W-1:0]          DIFF_LIMIT   = 9'd60;
	localparam logic signed [INTEG_W-1:0] INTEG_LIMIT  = 13'sd4000;
	localparam logic [CNT_W-1:0]          TICK_LIMIT   = 4'd10;

	// Output modes
	localparam logic [MODE_W-1:0] MODE_TRACK   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BLACK   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RECOVER = 2'd2;
	localparam logic [MODE_W-1:0] MODE_LOST    = 2'd3;

	// Reading classes set by the front
	localparam logic [CLS_W-1:0] CLS_TRACK   = 2'd0;
	localparam logic [CLS_W-1:0] CLS_ALL     = 2'd1;
	localparam logic [CLS_W-1:0] CLS_NONE    = 2'd2;
	localparam logic [CLS_W-1:0] CLS_INVALID = 2'd3;

	// Remembered turn side
	localparam logic [DIR_W-1:0] DIR_NONE  = 2'd0;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROP      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd5;

	// Register reset values
	localparam logic [TGT_W-1:0]         RST_BASE      = 9'd30;
	localparam logic signed [GAIN_W-1:0] RST_PROP      = 18'sd459;
	localparam logic signed [GAIN_W-1:0] RST_INTEG     = 18'sd0;
	localparam logic signed [GAIN_W-1:0] RST_DERIV     = 18'sd1245;
	localparam logic [SAMPLE_W-1:0]      RST_THRESHOLD = 12'd500;

	// One classified reading
	typedef struct packed {
		logic [CLS_W-1:0]        cls;
		logic [NUM_SENSORS-1:0]  pattern;
		logic signed [ERR_W-1:0] err;
	} item_t;

	// Configuration register set
	typedef struct packed {
		logic                     enable;
		logic [TGT_W-1:0]         base_speed;
		logic signed [GAIN_W-1:0] prop_gain;
		logic signed [GAIN_W-1:0] integ_gain;
		logic signed [GAIN_W-1:0] deriv_gain;
		logic [SAMPLE_W-1:0]      threshold;
	} cfg_t;

	// Clear requests raised by register writes
	typedef struct packed {
		logic clr_state;
		logic clr_integ;
	} cfg_evt_t;

endpackage

// ----- hdl/lfps_front.sv -----
// Front: accepts sensor readings, thresholds the samples and classifies each beat.
module lfps_front (
	input  logic                                                    enable,
	input  logic [lfps_pkg::SAMPLE_W-1:0]                           threshold,
	input  logic                                                    in_valid,
	output logic                                                    in_ready,
	input  logic                                                    reading_valid,
	input  logic [lfps_pkg::NUM_SENSORS-1:0][lfps_pkg::SAMPLE_W-1:0] samples,
	input  logic signed [lfps_pkg::ERR_W-1:0]                       line_error,
	input  logic                                                    q_full,
	output logic                                                    push,
	output lfps_pkg::item_t                                         push_item
);
	import lfps_pkg::*;

	logic [NUM_SENSORS-1:0] pattern;

	// Threshold compare per sensor
	always_comb begin
		for (int i = 0; i < NUM_SENSORS; i++) begin
			pattern[i] = (samples[i] >= threshold);
		end
	end

	// Classify the reading
	always_comb begin
		push_item.err = line_error;
		if (!reading_valid) begin
			push_item.cls     = CLS_INVALID;
			push_item.pattern = '0;
		end else if (pattern == '0) begin
			push_item.cls     = CLS_NONE;
			push_item.pattern = pattern;
		end else if (pattern == '1) begin
			push_item.cls     = CLS_ALL;
			push_item.pattern = pattern;
		end else begin
			push_item.cls     = CLS_TRACK;
			push_item.pattern = pattern;
		end
	end

	// Beats taken while disabled are dropped
	assign in_ready = !q_full;
	assign push     = in_valid && in_ready && enable;

endmodule

// ----- hdl/lfps_queue.sv -----
// Short queue of classified readings between front and back.
module lfps_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lfps_pkg::item_t push_item,
	input  logic            pop,
	output logic            q_valid,
	output logic            q_full,
	output lfps_pkg::item_t q_item
);
	import lfps_pkg::*;

	item_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_CNT_W-1:0]  count_q;

	assign q_valid = (count_q != '0);
	assign q_full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign q_item  = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- hdl/lfps_back.sv -----
// Back: steering state, shared PID multiplier sequence and the result register.
module lfps_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lfps_pkg::cfg_t                      cfg,
	input  lfps_pkg::cfg_evt_t                  evt,
	input  logic                                q_valid,
	input  lfps_pkg::item_t                     q_item,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [lfps_pkg::TGT_W-1:0]          left_target,
	output logic [lfps_pkg::TGT_W-1:0]          right_target,
	output logic [lfps_pkg::MODE_W-1:0]         mode,
	output logic [lfps_pkg::NUM_SENSORS-1:0]    active_bits,
	output logic signed [lfps_pkg::DIFF_W-1:0]  steer_diff
);
	import lfps_pkg::*;

	// Multiplier sequence phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MUL1 = 2'd1;
	localparam logic [1:0] PH_MUL2 = 2'd2;
	localparam logic [1:0] PH_MUL3 = 2'd3;

	localparam int RND_W = ACC_W - 16;
	localparam int SUM_W = TGT_W + 2;

	// Clamp a wheel target to 0..300
	function automatic logic [TGT_W-1:0] sat_target(input logic signed [SUM_W-1:0] v);
		logic [TGT_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({2'b00, TARGET_LIMIT})) begin
			r = TARGET_LIMIT;
		end else begin
			r = v[TGT_W-1:0];
		end
		return r;
	endfunction

	// Control state
	logic [1:0]                 phase_q;
	logic                       fin_v_q;
	logic                       out_v_q;
	logic signed [INTEG_W-1:0]  integ_q;
	logic signed [ERR_W-1:0]    prev_err_q;
	logic [DIR_W-1:0]           turn_q;
	logic [CNT_W-1:0]           lost_cnt_q;
	logic [CNT_W-1:0]           black_cnt_q;

	// Datapath registers
	logic signed [PROD_W-1:0]   p_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ACC_W-1:0]    sum_q;
	logic signed [OPND_W-1:0]   op_i_q;
	logic signed [OPND_W-1:0]   op_d_q;
	logic [NUM_SENSORS-1:0]     trk_pat_q;
	logic [NUM_SENSORS-1:0]     fin_pat_q;
	logic [TGT_W-1:0]           left_q;
	logic [TGT_W-1:0]           right_q;
	logic [MODE_W-1:0]          mode_q;
	logic [NUM_SENSORS-1:0]     bits_q;
	logic signed [DIFF_W-1:0]   diff_q;

	// Combinational
	logic [TGT_W-1:0]           base_eff;
	logic [TGT_W-1:0]           half;
	logic                       is_trk;
	logic                       out_free;
	logic                       fin_go;
	logic                       mul3_go;
	logic signed [OPND_W-1:0]   err_x;
	logic signed [INTEG_W:0]    integ_sum;
	logic signed [INTEG_W-1:0]  integ_new;
	logic signed [OPND_W-1:0]   der;
	logic [DIR_W-1:0]           rec_dir;
	logic signed [DIFF_W-1:0]   pd;
	logic signed [GAIN_W-1:0]   mul_a;
	logic signed [OPND_W-1:0]   mul_b;
	logic signed [PROD_W-1:0]   product;
	logic signed [ACC_W-1:0]    sum_r;
	logic signed [RND_W-1:0]    rnd;
	logic [TGT_W-1:0]           lim;
	logic signed [RND_W-1:0]    lim_s;
	logic signed [DIFF_W-1:0]   fin_diff;
	logic [TGT_W-1:0]           dir_left;
	logic [TGT_W-1:0]           dir_right;
	logic [MODE_W-1:0]          dir_mode;
	logic signed [DIFF_W-1:0]   dir_diff;

	assign base_eff = (cfg.base_speed > TARGET_LIMIT) ? TARGET_LIMIT : cfg.base_speed;
	assign half     = {1'b0, base_eff[TGT_W-1:1]};
	assign is_trk   = (q_item.cls == CLS_TRACK);
	assign out_free = !out_v_q || out_ready;
	assign fin_go   = fin_v_q && out_free;
	assign mul3_go  = (phase_q == PH_MUL3) && (!fin_v_q || fin_go);

	// Older finished track result has the output first
	assign pop = q_valid && (phase_q == PH_IDLE) && (is_trk || (!fin_v_q && out_free));

	// Integrator and derivative of the head reading
	assign err_x     = {q_item.err[ERR_W-1], q_item.err};
	assign integ_sum = {integ_q[INTEG_W-1], integ_q} + {{2{q_item.err[ERR_W-1]}}, q_item.err};
	assign der       = err_x - {prev_err_q[ERR_W-1], prev_err_q};

	always_comb begin
		if (integ_sum > $signed({INTEG_LIMIT[INTEG_W-1], INTEG_LIMIT})) begin
			integ_new = INTEG_LIMIT;
		end else if (integ_sum < -$signed({INTEG_LIMIT[INTEG_W-1], INTEG_LIMIT})) begin
			integ_new = -INTEG_LIMIT;
		end else begin
			integ_new = integ_sum[INTEG_W-1:0];
		end
	end

	// Recovery side and differential
	assign rec_dir = (turn_q != DIR_NONE) ? turn_q :
		(prev_err_q < 0 ? DIR_LEFT : DIR_RIGHT);
	assign pd = (rec_dir == DIR_LEFT) ? -$signed(half) : $signed(half);

	// Shared multiplier: one gain term per cycle
	always_comb begin
		case (phase_q)
			PH_IDLE: begin
				mul_a = cfg.prop_gain;
				mul_b = err_x;
			end
			PH_MUL1: begin
				mul_a = cfg.integ_gain;
				mul_b = op_i_q;
			end
			default: begin
				mul_a = cfg.deriv_gain;
				mul_b = op_d_q;
			end
		endcase
	end
	assign product = mul_a * mul_b;

	// Round half away from zero, then clamp to +-min(base,60)
	assign sum_r = sum_q + (sum_q[ACC_W-1] ? ACC_W'(32767) : ACC_W'(32768));
	assign rnd   = sum_r[ACC_W-1:16];
	assign lim   = (base_eff < DIFF_LIMIT) ? base_eff : DIFF_LIMIT;
	assign lim_s = $signed(RND_W'(lim));

	always_comb begin
		if (rnd > lim_s) begin
			fin_diff = $signed(lim);
		end else if (rnd < -lim_s) begin
			fin_diff = -$signed(lim);
		end else begin
			fin_diff = rnd[DIFF_W-1:0];
		end
	end

	// Direct result for readings that skip the PID
	always_comb begin
		dir_left  = '0;
		dir_right = '0;
		dir_diff  = '0;
		case (q_item.cls)
			CLS_INVALID: begin
				dir_mode = MODE_LOST;
			end
			CLS_NONE: begin
				if (lost_cnt_q < TICK_LIMIT) begin
					dir_mode  = MODE_RECOVER;
					dir_left  = sat_target($signed({2'b00, base_eff}) + SUM_W'(pd));
					dir_right = sat_target($signed({2'b00, base_eff}) - SUM_W'(pd));
					dir_diff  = pd;
				end else begin
					dir_mode = MODE_LOST;
				end
			end
			CLS_ALL: begin
				dir_mode = MODE_BLACK;
				if (black_cnt_q < TICK_LIMIT) begin
					dir_left  = half;
					dir_right = half;
				end
			end
			default: begin
				dir_mode = MODE_TRACK;
			end
		endcase
	end

	// Control state and steering memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			fin_v_q     <= 1'b0;
			out_v_q     <= 1'b0;
			integ_q     <= '0;
			prev_err_q  <= '0;
			turn_q      <= DIR_NONE;
			lost_cnt_q  <= '0;
			black_cnt_q <= '0;
		end else begin
			// multiply sequence
			case (phase_q)
				PH_IDLE: begin
					if (pop && is_trk) begin
						phase_q <= PH_MUL1;
					end
				end
				PH_MUL1: phase_q <= PH_MUL2;
				PH_MUL2: phase_q <= PH_MUL3;
				default: begin
					if (mul3_go) begin
						phase_q <= PH_IDLE;
					end
				end
			endcase

			// finish stage
			if (mul3_go) begin
				fin_v_q <= 1'b1;
			end else if (fin_go) begin
				fin_v_q <= 1'b0;
			end

			// result register
			if (fin_go || (pop && !is_trk)) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end

			// state per reading class
			if (pop) begin
				case (q_item.cls)
					CLS_INVALID: begin
						integ_q     <= '0;
						prev_err_q  <= '0;
						turn_q      <= DIR_NONE;
						lost_cnt_q  <= '0;
						black_cnt_q <= '0;
					end
					CLS_NONE: begin
						black_cnt_q <= '0;
						integ_q     <= '0;
						turn_q      <= rec_dir;
						if (lost_cnt_q < TICK_LIMIT) begin
							lost_cnt_q <= lost_cnt_q + 1'b1;
						end
					end
					CLS_ALL: begin
						lost_cnt_q <= '0;
						integ_q    <= '0;
						if (black_cnt_q < TICK_LIMIT) begin
							black_cnt_q <= black_cnt_q + 1'b1;
						end
					end
					default: begin
						lost_cnt_q  <= '0;
						black_cnt_q <= '0;
						integ_q     <= integ_new;
						prev_err_q  <= q_item.err;
						if (q_item.err < 0) begin
							turn_q <= DIR_LEFT;
						end else if (q_item.err > 0) begin
							turn_q <= DIR_RIGHT;
						end
					end
				endcase
			end

			// register writes clear state (the user must write only while idle; the block does not enforce it)
			if (evt.clr_state) begin
				integ_q     <= '0;
				prev_err_q  <= '0;
				turn_q      <= DIR_NONE;
				lost_cnt_q  <= '0;
				black_cnt_q <= '0;
			end else if (evt.clr_integ) begin
				integ_q <= '0;
			end
		end
	end

	// Datapath: products, accumulation, result payload
	always_ff @(posedge clk) begin
		if (phase_q != PH_MUL3) begin
			p_q <= product;
		end
		if (pop && is_trk) begin
			op_i_q    <= {integ_new};
			op_d_q    <= der;
			trk_pat_q <= q_item.pattern;
		end
		if (phase_q == PH_MUL1) begin
			acc_q <= ACC_W'(p_q);
		end else if (phase_q == PH_MUL2) begin
			acc_q <= acc_q + ACC_W'(p_q);
		end
		if (mul3_go) begin
			sum_q     <= acc_q + ACC_W'(p_q);
			fin_pat_q <= trk_pat_q;
		end
		if (fin_go) begin
			left_q  <= sat_target($signed({2'b00, base_eff}) + SUM_W'(fin_diff));
			right_q <= sat_target($signed({2'b00, base_eff}) - SUM_W'(fin_diff));
			mode_q  <= MODE_TRACK;
			bits_q  <= fin_pat_q;
			diff_q  <= fin_diff;
		end else if (pop && !is_trk) begin
			left_q  <= dir_left;
			right_q <= dir_right;
			mode_q  <= dir_mode;
			bits_q  <= q_item.pattern;
			diff_q  <= dir_diff;
		end
	end

	assign out_valid    = out_v_q;
	assign left_target  = left_q;
	assign right_target = right_q;
	assign mode         = mode_q;
	assign active_bits  = bits_q;
	assign steer_diff   = diff_q;

endmodule

// ----- hdl/line_follow_pid_steering.sv -----
// Top level of the line follower PID steering block: registers and front/queue/back.
//
// Each input beat is one sensor reading; each gives one result beat while the
// block is enabled and none while it is disabled. The front takes a beat every
// cycle while the two-entry queue has room; the back turns readings with no
// active sensor, all sensors active or an invalid flag into a registered result and
// runs line-tracking readings through one shared 18x13 multiplier, one gain term a
// cycle, taking no reading until idle again; such a result passes MUL1-MUL3, the
// finish stage and the result register. The user must write registers through
// cfg_we/cfg_idx/cfg_data only while the block is idle, not enforced by it; writing
// a gain clears the integrator and changing enable clears all steering state.
module line_follow_pid_steering (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lfps_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [lfps_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                reading_valid,
	input  logic [lfps_pkg::SAMPLE_W-1:0]       sample_0,
	input  logic [lfps_pkg::SAMPLE_W-1:0]       sample_1,
	input  logic [lfps_pkg::SAMPLE_W-1:0]       sample_2,
	input  logic [lfps_pkg::SAMPLE_W-1:0]       sample_3,
	input  logic [lfps_pkg::SAMPLE_W-1:0]       sample_4,
	input  logic signed [lfps_pkg::ERR_W-1:0]   line_error,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [lfps_pkg::TGT_W-1:0]          left_target,
	output logic [lfps_pkg::TGT_W-1:0]          right_target,
	output logic [lfps_pkg::MODE_W-1:0]         mode,
	output logic [lfps_pkg::NUM_SENSORS-1:0]    active_bits,
	output logic signed [lfps_pkg::DIFF_W-1:0]  steer_diff
);
	import lfps_pkg::*;

	cfg_t                              cfg_q;
	cfg_evt_t                          evt;
	logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] samples;
	logic                              push;
	item_t                             push_item;
	logic                              pop;
	logic                              q_valid;
	logic                              q_full;
	item_t                             q_item;

	assign samples = {sample_4, sample_3, sample_2, sample_1, sample_0};

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable     <= 1'b0;
			cfg_q.base_speed <= RST_BASE;
			cfg_q.prop_gain  <= RST_PROP;
			cfg_q.integ_gain <= RST_INTEG;
			cfg_q.deriv_gain <= RST_DERIV;
			cfg_q.threshold  <= RST_THRESHOLD;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ENABLE:    cfg_q.enable     <= cfg_data[0];
				REG_BASE:      cfg_q.base_speed <= cfg_data[TGT_W-1:0];
				REG_PROP:      cfg_q.prop_gain  <= $signed(cfg_data[GAIN_W-1:0]);
				REG_INTEG:     cfg_q.integ_gain <= $signed(cfg_data[GAIN_W-1:0]);
				REG_DERIV:     cfg_q.deriv_gain <= $signed(cfg_data[GAIN_W-1:0]);
				REG_THRESHOLD: cfg_q.threshold  <= cfg_data[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Clear requests from writes
	assign evt.clr_state = cfg_we && (cfg_idx == REG_ENABLE) && (cfg_data[0] != cfg_q.enable);
	assign evt.clr_integ = cfg_we && ((cfg_idx == REG_PROP) || (cfg_idx == REG_INTEG) ||
		(cfg_idx == REG_DERIV));

	lfps_front u_front (
		.enable        (cfg_q.enable),
		.threshold     (cfg_q.threshold),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.reading_valid (reading_valid),
		.samples       (samples),
		.line_error    (line_error),
		.q_full        (q_full),
		.push          (push),
		.push_item     (push_item)
	);

	lfps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_full    (q_full),
		.q_item    (q_item)
	);

	lfps_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.evt          (evt),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.left_target  (left_target),
		.right_target (right_target),
		.mode         (mode),
		.active_bits  (active_bits),
		.steer_diff   (steer_diff)
	);

endmodule

// ----- hdl/lfps_checker.sv -----
// Port-level checks on the steering results, bound to the top level.
module lfps_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [lfps_pkg::TGT_W-1:0]          left_target,
	input logic [lfps_pkg::TGT_W-1:0]          right_target,
	input logic [lfps_pkg::MODE_W-1:0]         mode,
	input logic [lfps_pkg::NUM_SENSORS-1:0]    active_bits,
	input logic signed [lfps_pkg::DIFF_W-1:0]  steer_diff
);
	import lfps_pkg::*;

	// Stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_target) &&
		$stable(right_target) && $stable(mode) && $stable(steer_diff))
		else $error("result beat changed while stalled");

	// Targets stay in range
	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (left_target <= TARGET_LIMIT) && (right_target <= TARGET_LIMIT))
		else $error("wheel target above limit");

	// Tracking: steering right never slows the left wheel below the right
	a_track_side: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (mode == MODE_TRACK) && !steer_diff[DIFF_W-1] |->
		left_target >= right_target)
		else $error("tracking targets disagree with differential sign");

	// Lost stops both wheels
	a_lost_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (mode == MODE_LOST) |->
		(left_target == '0) && (right_target == '0) && (steer_diff == '0))
		else $error("lost mode with wheels running");

	// All black runs straight with the full pattern
	a_black_straight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (mode == MODE_BLACK) |->
		(left_target == right_target) && (active_bits == '1) && (steer_diff == '0))
		else $error("all-black result not straight");

endmodule

bind line_follow_pid_steering lfps_checker u_lfps_checker (.*);

// ----- dv/line_follow_pid_steering_test.sv -----
// Self-checking testbench for the line follower PID steering block.
module line_follow_pid_steering_test;
	import lfps_pkg::*;

	localparam int SETTLE_CYCLES = 30;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 400000;

	// One sensor reading as offered on the input channel
	typedef struct packed {
		logic                                 ok;
		logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] smp;
		logic signed [ERR_W-1:0]              err;
	} reading_t;

	// One steering result
	typedef struct packed {
		logic [TGT_W-1:0]         left;
		logic [TGT_W-1:0]         right;
		logic [MODE_W-1:0]        mode;
		logic [NUM_SENSORS-1:0]   bits;
		logic signed [DIFF_W-1:0] diff;
	} steer_t;

	// Block ports
	logic                    clk;
	logic                    arst_n        = 1'b0;
	logic                    cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_idx       = '0;
	logic [CFG_DATA_W-1:0]   cfg_data      = '0;
	logic                    in_valid      = 1'b0;
	logic                    in_ready;
	logic                    reading_valid = 1'b0;
	logic [SAMPLE_W-1:0]     sample_0      = '0;
	logic [SAMPLE_W-1:0]     sample_1      = '0;
	logic [SAMPLE_W-1:0]     sample_2      = '0;
	logic [SAMPLE_W-1:0]     sample_3      = '0;
	logic [SAMPLE_W-1:0]     sample_4      = '0;
	logic signed [ERR_W-1:0] line_error    = '0;
	logic                    out_valid;
	logic                    out_ready     = 1'b0;
	logic [TGT_W-1:0]        left_target;
	logic [TGT_W-1:0]        right_target;
	logic [MODE_W-1:0]       mode;
	logic [NUM_SENSORS-1:0]  active_bits;
	logic signed [DIFF_W-1:0] steer_diff;

	line_follow_pid_steering uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.reading_valid(reading_valid),
		.sample_0     (sample_0),
		.sample_1     (sample_1),
		.sample_2     (sample_2),
		.sample_3     (sample_3),
		.sample_4     (sample_4),
		.line_error   (line_error),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.left_target  (left_target),
		.right_target (right_target),
		.mode         (mode),
		.active_bits  (active_bits),
		.steer_diff   (steer_diff)
	);

	// Register copies
	logic             cfg_en;
	logic [TGT_W-1:0] cfg_base;
	int               cfg_kp;
	int               cfg_ki;
	int               cfg_kd;
	logic [SAMPLE_W-1:0] cfg_thr;

	// Steering state copies (the recovery differential is worked out per reading, so not kept)
	int                     trk_integ;
	int                     trk_prev_err;
	logic [DIR_W-1:0]       trk_dir;
	int                     trk_lost_cnt;
	int                     trk_black_cnt;
	logic [MODE_W-1:0]      trk_mode;
	logic [NUM_SENSORS-1:0] trk_pattern;

	reading_t pending_readings[$];
	steer_t   expected_steer[$];
	reading_t offered;
	steer_t   mon_want;
	steer_t   mon_got;

	int   err_walk;
	bit   sender_eager;
	int   burst_left;
	int   gap_left;
	int   hold_asked;
	int   hold_served;
	int   hold_left;
	int   rx_style;
	logic [15:0] rx_tick;
	int   fault_count;
	int   cycle_count;

	function automatic int clip(int v, int lo, int hi);
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	function automatic void clear_track();
		trk_integ     = 0;
		trk_prev_err  = 0;
		trk_pattern   = '0;
		trk_dir       = DIR_NONE;
		trk_lost_cnt  = 0;
		trk_black_cnt = 0;
	endfunction

	function automatic void expect_steer(int left, int right, int diff);
		steer_t s;
		s.left  = TGT_W'(clip(left, 0, int'(TARGET_LIMIT)));
		s.right = TGT_W'(clip(right, 0, int'(TARGET_LIMIT)));
		s.mode  = trk_mode;
		s.bits  = trk_pattern;
		s.diff  = DIFF_W'(diff);
		expected_steer.push_back(s);
	endfunction

	// Steering prediction for one accepted reading
	function automatic void steer_predict(reading_t rd);
		logic [NUM_SENSORS-1:0] bits;
		logic [DIR_W-1:0]       dir;
		int base, half, lim, err, der, diff;
		longint sum, mag;
		if (!cfg_en)
			return;
		if (!rd.ok) begin
			clear_track();
			trk_mode = MODE_LOST;
			expect_steer(0, 0, 0);
			return;
		end
		for (int i = 0; i < NUM_SENSORS; i++)
			bits[i] = (rd.smp[i] >= cfg_thr);
		trk_pattern = bits;
		base = (cfg_base > TARGET_LIMIT) ? int'(TARGET_LIMIT) : int'(cfg_base);
		half = base / 2;

		// line lost: turn toward the remembered side, then stop
		if (bits == '0) begin
			dir = trk_dir;
			trk_black_cnt = 0;
			if (dir == DIR_NONE)
				dir = (trk_prev_err < 0) ? DIR_LEFT : DIR_RIGHT;
			trk_dir = dir;
			trk_integ = 0;
			diff = (dir == DIR_LEFT) ? -half : half;
			if (trk_lost_cnt < int'(TICK_LIMIT)) begin
				trk_lost_cnt++;
				trk_mode = MODE_RECOVER;
				expect_steer(base + diff, base - diff, diff);
			end else begin
				trk_mode = MODE_LOST;
				expect_steer(0, 0, 0);
			end
			return;
		end

		// every sensor active: crawl, then stop
		if (bits == '1) begin
			trk_lost_cnt = 0;
			trk_mode = MODE_BLACK;
			trk_integ = 0;
			if (trk_black_cnt < int'(TICK_LIMIT)) begin
				trk_black_cnt++;
				expect_steer(half, half, 0);
			end else begin
				expect_steer(0, 0, 0);
			end
			return;
		end

		// tracking: PID in Q16, rounded half away from zero
		trk_lost_cnt = 0;
		trk_black_cnt = 0;
		err = rd.err;
		der = err - trk_prev_err;
		lim = (base < int'(DIFF_LIMIT)) ? base : int'(DIFF_LIMIT);
		trk_mode = MODE_TRACK;
		if (err < 0)
			trk_dir = DIR_LEFT;
		else if (err > 0)
			trk_dir = DIR_RIGHT;
		trk_integ = clip(trk_integ + err, -int'(INTEG_LIMIT), int'(INTEG_LIMIT));
		sum = longint'(cfg_kp) * err + longint'(cfg_ki) * trk_integ + longint'(cfg_kd) * der;
		mag = (sum < 0) ? -sum : sum;
		mag = (mag + 32768) >>> 16;
		if (mag > 1000)
			mag = 1000;
		diff = (sum < 0) ? -int'(mag) : int'(mag);
		diff = clip(diff, -lim, lim);
		trk_prev_err = err;
		expect_steer(base + diff, base - diff, diff);
	endfunction

	// Sample that lands on the wanted side of the threshold, often right at the edge
	function automatic logic [SAMPLE_W-1:0] sample_for(logic on);
		int thr;
		thr = cfg_thr;
		if (on) begin
			case ($urandom_range(0, 3))
				0: return SAMPLE_W'(thr);
				1: return '1;
				default: return SAMPLE_W'($urandom_range(thr, 4095));
			endcase
		end
		if (thr == 0)
			return '0;
		case ($urandom_range(0, 3))
			0: return SAMPLE_W'(thr - 1);
			1: return '0;
			default: return SAMPLE_W'($urandom_range(0, thr - 1));
		endcase
	endfunction

	function automatic void queue_samples(logic ok, logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] smp,
					int err);
		reading_t rd;
		rd.ok  = ok;
		rd.smp = smp;
		rd.err = ERR_W'(err);
		pending_readings.push_back(rd);
	endfunction

	function automatic void queue_reading(logic ok, logic [NUM_SENSORS-1:0] bits, int err);
		logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] smp;
		for (int i = 0; i < NUM_SENSORS; i++)
			smp[i] = sample_for(bits[i]);
		queue_samples(ok, smp, err);
	endfunction

	// One run of readings: mostly well-formed tracking/lost/black runs, some noise
	function automatic int queue_random_run();
		int kind, len;
		logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] raw;
		kind = $urandom_range(0, 99);
		len  = $urandom_range(1, 14);
		if (kind >= 82 && kind < 88)
			len = $urandom_range(1, 2);
		for (int n = 0; n < len; n++) begin
			if (kind < 55) begin
				case ($urandom_range(0, 11))
					0: err_walk = 2047;
					1: err_walk = -2048;
					2: err_walk = 0;
					default: err_walk = clip(err_walk + int'($urandom_range(0, 400)) - 200,
							-2048, 2047);
				endcase
				queue_reading(1'b1, NUM_SENSORS'($urandom_range(1, 30)), err_walk);
			end else if (kind < 70) begin
				queue_reading(1'b1, '0, err_walk);
			end else if (kind < 82) begin
				queue_reading(1'b1, '1, err_walk);
			end else if (kind < 88) begin
				queue_reading(1'b0, NUM_SENSORS'($urandom), int'($urandom_range(0, 4095)) - 2048);
			end else begin
				for (int i = 0; i < NUM_SENSORS; i++)
					raw[i] = SAMPLE_W'($urandom);
				queue_samples($urandom_range(0, 7) != 0, raw, int'($urandom_range(0, 4095)) - 2048);
			end
		end
		return len;
	endfunction

	function automatic int pick_gain();
		case ($urandom_range(0, 4))
			0: return int'($urandom_range(0, 262143)) - 131072;
			1: return 0;
			default: return int'($urandom_range(0, 8000)) - 4000;
		endcase
	endfunction

	// Register write; the copies change as the write is driven, which is safe since the block is idle
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= CFG_DATA_W'(value);
		case (idx)
			REG_ENABLE: begin
				if (value[0] != cfg_en) begin
					clear_track();
					trk_mode = value[0] ? MODE_TRACK : MODE_LOST;
				end
				cfg_en = value[0];
			end
			REG_BASE: cfg_base = value[TGT_W-1:0];
			REG_PROP: begin
				cfg_kp = $signed(value[GAIN_W-1:0]);
				trk_integ = 0;
			end
			REG_INTEG: begin
				cfg_ki = $signed(value[GAIN_W-1:0]);
				trk_integ = 0;
			end
			REG_DERIV: begin
				cfg_kd = $signed(value[GAIN_W-1:0]);
				trk_integ = 0;
			end
			REG_THRESHOLD: cfg_thr = value[SAMPLE_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_settings(int base, int kp, int ki, int kd, int thr);
		write_reg(REG_BASE, base);
		write_reg(REG_PROP, kp);
		write_reg(REG_INTEG, ki);
		write_reg(REG_DERIV, kd);
		write_reg(REG_THRESHOLD, thr);
	endtask

	// Wait until every reading is taken and every result is back, then let the pipe drain
	task automatic settle();
		do
			@(negedge clk);
		while (pending_readings.size() != 0 || in_valid || expected_steer.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(int n_items, bit long_hold);
		int added;
		added = 0;
		sender_eager = ($urandom_range(0, 2) == 0) || long_hold;
		if (long_hold)
			hold_asked++;
		while (added < n_items)
			added += queue_random_run();
		settle();
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Sender: bursts of beats with random gaps, none when eager
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (in_valid && in_ready)
				steer_predict(offered);
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_readings.size() != 0) begin
					offered = pending_readings.pop_front();
					reading_valid <= offered.ok;
					sample_0      <= offered.smp[0];
					sample_1      <= offered.smp[1];
					sample_2      <= offered.smp[2];
					sample_3      <= offered.smp[3];
					sample_4      <= offered.smp[4];
					line_error    <= offered.err;
					in_valid      <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left   <= sender_eager ? 0 : $urandom_range(1, 9);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: new stall style whenever the low six bits of its tick counter are zero; long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready   <= 1'b0;
			hold_served <= 0;
			hold_left   <= 0;
			rx_style    <= 0;
			rx_tick     <= '0;
		end else if (hold_asked != hold_served) begin
			hold_served <= hold_asked;
			hold_left   <= HOLD_CYCLES;
			out_ready   <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			rx_tick <= rx_tick + 1'b1;
			if (rx_tick[5:0] == 6'd0)
				rx_style <= $urandom_range(0, 3);
			case (rx_style)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) == 1);
				2: out_ready <= (rx_tick[1:0] == 2'd0);
				default: out_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			mon_got.left  = left_target;
			mon_got.right = right_target;
			mon_got.mode  = mode;
			mon_got.bits  = active_bits;
			mon_got.diff  = steer_diff;
			if (expected_steer.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected beat: left %0d right %0d mode %0d bits %b diff %0d",
						mon_got.left, mon_got.right, mon_got.mode, mon_got.bits, mon_got.diff);
			end else begin
				mon_want = expected_steer.pop_front();
				if (mon_got !== mon_want) begin
					fault_count++;
					if (fault_count <= 10)
						$display({"mismatch: expected left %0d right %0d mode %0d bits %b diff %0d,",
							" got left %0d right %0d mode %0d bits %b diff %0d"},
							mon_want.left, mon_want.right, mon_want.mode, mon_want.bits,
							mon_want.diff, mon_got.left, mon_got.right, mon_got.mode,
							mon_got.bits, mon_got.diff);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Stimulus and register schedule
	initial begin
		cfg_en       = 1'b0;
		cfg_base     = RST_BASE;
		cfg_kp       = RST_PROP;
		cfg_ki       = RST_INTEG;
		cfg_kd       = RST_DERIV;
		cfg_thr      = RST_THRESHOLD;
		clear_track();
		trk_mode     = MODE_LOST;
		err_walk     = 0;
		sender_eager = 1'b0;
		hold_asked   = 0;
		fault_count  = 0;
		cycle_count  = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// disabled after reset: readings are swallowed
		void'(queue_random_run());
		void'(queue_random_run());
		settle();

		// directed readings at reset gains
		write_reg(REG_ENABLE, 1);
		queue_samples(1'b0, {NUM_SENSORS{12'hFFF}}, 2047);
		queue_samples(1'b1, '0, -2048);          // nothing seen, no side remembered
		queue_reading(1'b1, 5'b00001, -2048);
		queue_reading(1'b1, 5'b00010, 2047);
		queue_reading(1'b1, 5'b00100, 0);
		queue_reading(1'b1, 5'b01000, -1);
		queue_reading(1'b1, 5'b10000, 1);
		queue_samples(1'b1, '1, 0);              // all samples at full scale
		queue_samples(1'b1, {12'd500, 12'd499, 12'd500, 12'd499, 12'd500}, 5);
		queue_reading(1'b1, 5'b00100, -300);
		queue_reading(1'b1, '0, 0);              // recovers to the left
		queue_reading(1'b1, '0, 0);
		queue_reading(1'b1, '1, 0);
		queue_reading(1'b1, '1, 0);
		queue_reading(1'b1, 5'b00110, 2047);
		queue_samples(1'b0, '0, -2048);
		settle();

		// extreme settings
		apply_settings(300, -131072, -131072, -131072, 4095);
		run_phase(50, 1'b0);
		apply_settings(0, 131071, 131071, 131071, 0);
		run_phase(20, 1'b0);
		apply_settings(511, pick_gain(), pick_gain(), pick_gain(), 1);
		run_phase(60, 1'b1);
		apply_settings(60, pick_gain(), pick_gain(), pick_gain(), 2048);
		run_phase(60, 1'b0);
		apply_settings(61, pick_gain(), pick_gain(), pick_gain(), 4094);
		run_phase(60, 1'b0);

		// disable mid run: readings dropped, repeated writes of the same value
		write_reg(REG_ENABLE, 0);
		write_reg(REG_ENABLE, 0);
		run_phase(12, 1'b0);
		write_reg(REG_ENABLE, 1);
		write_reg(REG_ENABLE, 1);

		// random settings
		for (int p = 0; p < 5; p++) begin
			apply_settings(($urandom_range(0, 3) == 0) ? $urandom_range(301, 511)
					: $urandom_range(0, 300),
				pick_gain(), pick_gain(), pick_gain(),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
					: $urandom_range(200, 3000));
			run_phase(60, p == 2);
		end

		// a lone gain write clears only the integrator
		write_reg(REG_INTEG, pick_gain());
		run_phase(40, 1'b0);

		if (fault_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
